// ===== rtl/xo128_pkg.sv =====
// Shared types, constants and helper functions for the xoshiro128+ generator.
// Standalone package; used by every module under rtl/.
package xo128_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned FracW        = 24;
  localparam int unsigned WarmupSteps  = 20;
  localparam int unsigned RotAmount    = 11;
  localparam int unsigned ShiftAmount  = 9;
  localparam int unsigned SeedMuls     = 3;
  localparam int unsigned SeqCntW      = 5;

  localparam logic [WordW-1:0] ResetSeed = 32'd42;
  localparam logic [WordW-1:0] MulWord1  = 32'd2654435761;
  localparam logic [WordW-1:0] MulWord2  = 32'd2246822519;
  localparam logic [WordW-1:0] MulWord3  = 32'd3266489917;

  localparam logic [63:0] ResetProd1 = {32'd0, ResetSeed} * {32'd0, MulWord1};
  localparam logic [63:0] ResetProd2 = {32'd0, ResetSeed} * {32'd0, MulWord2};
  localparam logic [63:0] ResetProd3 = {32'd0, ResetSeed} * {32'd0, MulWord3};

  typedef logic [3:0][WordW-1:0] words_t;

  localparam words_t ResetWords = {ResetProd3[WordW-1:0], ResetProd2[WordW-1:0],
                                   ResetProd1[WordW-1:0], ResetSeed};

  typedef struct packed {
    logic             restart;
    logic [WordW-1:0] bound;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] raw_value;
    logic [FracW-1:0] fraction24;
    logic [WordW-1:0] bounded_value;
  } out_t;

  typedef struct packed {
    logic       mul_wr;
    logic [1:0] mul_sel;
    logic       step;
  } core_ctrl_t;

  function automatic logic [WordW-1:0] mul_const(input logic [1:0] sel);
    logic [WordW-1:0] c;
    case (sel)
      2'd0:    c = MulWord1;
      2'd1:    c = MulWord2;
      default: c = MulWord3;
    endcase
    return c;
  endfunction

  function automatic words_t advance(input words_t w);
    words_t           n;
    logic [WordW-1:0] shifted;
    shifted = w[1] << ShiftAmount;
    n = w;
    n[2] = n[2] ^ n[0];
    n[3] = n[3] ^ n[1];
    n[1] = n[1] ^ n[2];
    n[0] = n[0] ^ n[3];
    n[2] = n[2] ^ shifted;
    n[3] = (n[3] << RotAmount) | (n[3] >> (WordW - RotAmount));
    return n;
  endfunction

endpackage

// ===== rtl/xoshiro128_plus_generator.sv =====
// Path: draw and finish states to a result register, plus the divide state for a
//   nonzero bound; a restart first adds seeding (3 multiplies, 20 warm-up steps).
// Throughput: one transaction at a time; the 32-step remainder unit sets the rate.
// Reset: seed 42 loaded, then 20 warm-up steps with in_stall_o high.
// Top level; depends on xo128_pkg, xo128_core and xo128_div.
module xoshiro128_plus_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [xo128_pkg::WordW-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  xo128_pkg::in_t                     in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output xo128_pkg::out_t                    out_data_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEED   = 3'd1;
  localparam logic [2:0] ST_WARM   = 3'd2;
  localparam logic [2:0] ST_DRAW   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  localparam int unsigned CntW = xo128_pkg::SeqCntW;

  logic [2:0]                      state_q, state_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [xo128_pkg::WordW-1:0]     seed_q;
  logic [xo128_pkg::WordW-1:0]     bound_q, bound_d;
  logic [xo128_pkg::WordW-1:0]     raw_q, raw_d;
  logic [xo128_pkg::WordW-1:0]     bnd_res_q, bnd_res_d;
  logic                            out_valid_q, out_valid_d;
  xo128_pkg::out_t                 out_q, out_d;
  xo128_pkg::core_ctrl_t           core_ctrl;
  logic [xo128_pkg::WordW-1:0]     sum;
  logic                            div_start;
  logic                            div_done;
  logic [xo128_pkg::WordW-1:0]     div_rem;

  xo128_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (core_ctrl),
    .seed_i (seed_q),
    .sum_o  (sum)
  );

  xo128_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (raw_q),
    .divisor_i  (bound_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    bound_d     = bound_q;
    raw_d       = raw_q;
    bnd_res_d   = bnd_res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    core_ctrl   = '0;
    div_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          bound_d = in_data_i.bound;
          cnt_d   = '0;
          state_d = in_data_i.restart ? ST_SEED : ST_DRAW;
        end
      end
      ST_SEED: begin
        core_ctrl.mul_wr  = 1'b1;
        core_ctrl.mul_sel = cnt_q[1:0];
        cnt_d             = cnt_q + 1'b1;
        if (cnt_q == CntW'(xo128_pkg::SeedMuls - 1)) begin
          cnt_d   = '0;
          state_d = ST_WARM;
        end
      end
      ST_WARM: begin
        core_ctrl.step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(xo128_pkg::WarmupSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_DRAW: begin
        core_ctrl.step = 1'b1;
        raw_d          = sum;
        bnd_res_d      = '0;
        state_d        = (bound_q != '0) ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        div_start = (cnt_q == '0);
        cnt_d     = 5'd1;
        if (div_done) begin
          bnd_res_d = div_rem;
          cnt_d     = '0;
          state_d   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.raw_value     = raw_q;
          out_d.fraction24    = raw_q[xo128_pkg::WordW-1:xo128_pkg::WordW-xo128_pkg::FracW];
          out_d.bounded_value = bnd_res_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // warm-up after a restart returns to the draw, not to idle
  logic [2:0] state_nx;
  logic       restart_q, restart_d;
  assign restart_d = (state_q == ST_IDLE) ? (in_valid_i & in_data_i.restart) :
                     (state_q == ST_DRAW) ? 1'b0 : restart_q;
  assign state_nx  = (state_q == ST_WARM && state_d == ST_IDLE && restart_q) ?
                     ST_DRAW : state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WARM;
      cnt_q       <= '0;
      seed_q      <= xo128_pkg::ResetSeed;
      out_valid_q <= 1'b0;
      restart_q   <= 1'b0;
    end else begin
      state_q     <= state_nx;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      restart_q   <= restart_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q   <= bound_d;
    raw_q     <= raw_d;
    bnd_res_q <= bnd_res_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/xo128_core.sv =====
// Generator state: four 32-bit words, the advance step and a shared seeding multiplier.
// Depends on xo128_pkg.
module xo128_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  xo128_pkg::core_ctrl_t              ctrl_i,
  input  logic [xo128_pkg::WordW-1:0]        seed_i,
  output logic [xo128_pkg::WordW-1:0]        sum_o
);

  xo128_pkg::words_t                 words_q, words_d;
  logic [xo128_pkg::WordW-1:0]       prod;

  // one 32x32 low-half product, written to word sel+1; the first write also loads the seed into word 0
  assign prod  = seed_i * xo128_pkg::mul_const(ctrl_i.mul_sel);
  assign sum_o = words_q[0] + words_q[3];

  always_comb begin
    words_d = words_q;
    if (ctrl_i.mul_wr) begin
      words_d[ctrl_i.mul_sel + 2'd1] = prod;
      if (ctrl_i.mul_sel == 2'd0) begin
        words_d[0] = seed_i;
      end
    end else if (ctrl_i.step) begin
      words_d = xo128_pkg::advance(words_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= xo128_pkg::ResetWords;
    end else begin
      words_q <= words_d;
    end
  end

endmodule

// ===== rtl/xo128_div.sv =====
// Restoring remainder unit, one quotient bit per cycle.
// Depends on xo128_pkg.
module xo128_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [xo128_pkg::WordW-1:0]        dividend_i,
  input  logic [xo128_pkg::WordW-1:0]        divisor_i,
  output logic                               done_o,
  output logic [xo128_pkg::WordW-1:0]        rem_o
);

  localparam int unsigned W    = xo128_pkg::WordW;
  localparam int unsigned CntW = $clog2(W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    dvd_q, dvd_d;
  logic [W-1:0]    dvs_q, dvs_d;
  logic [W:0]      partial;
  logic [W:0]      diff;

  assign partial = {rem_q, dvd_q[W-1]};
  assign diff    = partial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = diff[W] ? partial[W-1:0] : diff[W-1:0];
      dvd_d = {dvd_q[W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/xo128_checker.sv =====
// Port-level checks for the xoshiro128+ generator, bound to the top level.
// Depends on xo128_pkg and xoshiro128_plus_generator.
module xo128_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input xo128_pkg::out_t              out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result transaction changed");

  a_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.fraction24 == out_data_o.raw_value[31:8])
    else $error("fraction24 does not match raw_value");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bounded_value <= out_data_o.raw_value)
    else $error("bounded_value exceeds raw_value");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted transaction");

endmodule

bind xoshiro128_plus_generator xo128_checker u_xo128_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for xoshiro128_plus_generator: random and directed draw requests
// checked against a behavioral model of the generator. Depends on xo128_pkg.
module testbench;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [xo128_pkg::WordW-1:0] cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  xo128_pkg::in_t              in_data_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  xo128_pkg::out_t             out_data_o;

  xoshiro128_plus_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // generator model state and seed register copy
  logic [xo128_pkg::WordW-1:0] prng_word [4];
  logic [xo128_pkg::WordW-1:0] seed_reg;

  xo128_pkg::in_t  req_q [$];
  xo128_pkg::out_t draw_q [$];
  int   n_sent = 0;
  int   n_taken = 0;
  int   n_restart = 0;
  int   n_bounded = 0;
  int   n_seeds = 0;
  int   n_err = 0;
  bit   quiet = 1'b0;

  function automatic logic [xo128_pkg::WordW-1:0] prng_next();
    logic [xo128_pkg::WordW-1:0] sum;
    logic [xo128_pkg::WordW-1:0] shifted;
    sum = prng_word[0] + prng_word[3];
    shifted = prng_word[1] << xo128_pkg::ShiftAmount;
    prng_word[2] = prng_word[2] ^ prng_word[0];
    prng_word[3] = prng_word[3] ^ prng_word[1];
    prng_word[1] = prng_word[1] ^ prng_word[2];
    prng_word[0] = prng_word[0] ^ prng_word[3];
    prng_word[2] = prng_word[2] ^ shifted;
    prng_word[3] = (prng_word[3] << xo128_pkg::RotAmount) |
                   (prng_word[3] >> (xo128_pkg::WordW - xo128_pkg::RotAmount));
    return sum;
  endfunction

  function automatic void prng_reseed(input logic [xo128_pkg::WordW-1:0] s);
    prng_word[0] = s;
    prng_word[1] = s * xo128_pkg::MulWord1;
    prng_word[2] = s * xo128_pkg::MulWord2;
    prng_word[3] = s * xo128_pkg::MulWord3;
    repeat (xo128_pkg::WarmupSteps) void'(prng_next());
  endfunction

  function automatic xo128_pkg::in_t rand_request(input int restart_pct);
    xo128_pkg::in_t r;
    r.restart = ($urandom_range(99) < restart_pct);
    case ($urandom_range(9))
      0, 1:    r.bound = '0;
      2, 3:    r.bound = $urandom_range(255, 1);
      4:       r.bound = 32'd1 << $urandom_range(31);
      5:       r.bound = 32'hFFFF_FFFF - $urandom_range(15);
      6:       r.bound = $urandom_range(65535, 1);
      default: r.bound = $urandom;
    endcase
    return r;
  endfunction

  function automatic xo128_pkg::in_t req(input logic restart,
                                         input logic [xo128_pkg::WordW-1:0] bound);
    xo128_pkg::in_t r;
    r.restart = restart;
    r.bound = bound;
    return r;
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin : drive
    logic           nv;
    xo128_pkg::in_t nd;
    nv = in_valid_i;
    nd = in_data_i;
    if (rst_ni) begin
      if (in_valid_i && n_taken == n_sent) nv = 1'b0;
      if (!nv && req_q.size() > 0 && (quiet || $urandom_range(99) >= 31)) begin
        nd = req_q.pop_front();
        nv = 1'b1;
        n_sent++;
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 31);
    end
    in_valid_i <= nv;
    in_data_i <= nd;
  end

  // monitor: predicts on each accepted request, checks each accepted draw
  always @(posedge clk_i) begin : watch
    xo128_pkg::out_t             want;
    logic [xo128_pkg::WordW-1:0] raw;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        n_taken++;
        if (in_data_i.restart) begin
          prng_reseed(seed_reg);
          n_restart++;
        end
        raw = prng_next();
        want.raw_value = raw;
        want.fraction24 = raw[xo128_pkg::WordW-1:xo128_pkg::WordW-xo128_pkg::FracW];
        want.bounded_value = (in_data_i.bound != '0) ? raw % in_data_i.bound : '0;
        if (in_data_i.bound != '0) n_bounded++;
        draw_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (draw_q.size() == 0) begin
          if (n_err < 10) $display("%0t: unexpected draw raw=%h", $realtime, out_data_o.raw_value);
          n_err++;
        end else begin
          want = draw_q.pop_front();
          if (out_data_o.raw_value !== want.raw_value ||
              out_data_o.fraction24 !== want.fraction24 ||
              out_data_o.bounded_value !== want.bounded_value) begin
            if (n_err < 10)
              $display("%0t: mismatch raw %h/%h frac %h/%h bounded %h/%h (exp/act)",
                       $realtime, want.raw_value, out_data_o.raw_value,
                       want.fraction24, out_data_o.fraction24,
                       want.bounded_value, out_data_o.bounded_value);
            n_err++;
          end
        end
      end
    end
  end

  task automatic settle();
    while (req_q.size() > 0 || n_taken != n_sent || draw_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [xo128_pkg::WordW-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    seed_reg = v;
    n_seeds++;
  endtask

  initial begin : stimulus
    logic [xo128_pkg::WordW-1:0] seeds [5];
    seeds[0] = 32'd1;
    seeds[1] = $urandom;
    seeds[2] = 32'h8000_0000;
    seeds[3] = $urandom;
    seeds[4] = xo128_pkg::ResetSeed;
    seed_reg = xo128_pkg::ResetSeed;
    prng_reseed(seed_reg);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // state from reset seed, bound extremes, restarts
    @(posedge clk_i);
    req_q.push_back(req(1'b0, 32'd0));
    req_q.push_back(req(1'b0, 32'd1));
    req_q.push_back(req(1'b0, 32'hFFFF_FFFF));
    req_q.push_back(req(1'b0, 32'hFFFF_FFFE));
    req_q.push_back(req(1'b1, 32'd0));
    req_q.push_back(req(1'b1, 32'd2));
    req_q.push_back(req(1'b0, 32'h8000_0000));
    req_q.push_back(req(1'b0, 32'h7FFF_FFFF));
    req_q.push_back(req(1'b1, 32'hFFFF_FFFF));
    req_q.push_back(req(1'b0, 32'd3));
    req_q.push_back(req(1'b0, 32'd255));
    req_q.push_back(req(1'b0, 32'hAAAA_5555));
    settle();

    // zero seed: fixed point, every draw after the restart is zero
    write_seed(32'd0);
    @(posedge clk_i);
    req_q.push_back(req(1'b0, 32'd7));
    req_q.push_back(req(1'b1, 32'd7));
    req_q.push_back(req(1'b0, 32'd0));
    req_q.push_back(req(1'b0, 32'hFFFF_FFFF));
    settle();

    write_seed(32'hFFFF_FFFF);
    @(posedge clk_i);
    req_q.push_back(req(1'b0, 32'd10));
    req_q.push_back(req(1'b1, 32'h5555_AAAA));
    req_q.push_back(req(1'b0, 32'd1));
    req_q.push_back(req(1'b1, 32'd0));
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      write_seed(seeds[ph]);
      quiet = (ph == 2);
      for (int k = 0; k < 86; k++) begin
        @(posedge clk_i);
        req_q.push_back(rand_request((k == 0 && ph[0]) ? 100 : 8));
      end
      settle();
      quiet = 1'b0;
    end

    if (draw_q.size() != 0) begin
      $display("%0d expected draws never arrived", draw_q.size());
      n_err++;
    end
    $display("%0d draws checked: %0d restarts, %0d bounded, %0d seed writes",
             n_taken, n_restart, n_bounded, n_seeds);
    $display("%0d mismatches", n_err);
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d draws outstanding", draw_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/xo128_pkg.sv
rtl/xo128_core.sv
rtl/xo128_div.sv
rtl/xoshiro128_plus_generator.sv
rtl/xo128_checker.sv
dv/testbench.sv
